// ===== sv/box_collision_first_hit_search_macros.svh =====
// Assertion macros used by the box collision search checker.
`ifndef BOX_COLLISION_FIRST_HIT_SEARCH_MACROS_SVH
`define BOX_COLLISION_FIRST_HIT_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCFHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcfhs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCFHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcfhs assertion failed");

`endif

// ===== sv/bcfhs_pkg.sv =====
// Shared types and constants for the box collision first-hit search.
`timescale 1ns / 1ps
package bcfhs_pkg;

	localparam int unsigned MAX_OBSTACLES_DEF = 64;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned TEX_W   = 10;
	localparam int unsigned SIZE_W  = 8;
	localparam int unsigned HIDX_W  = 6;

	localparam logic [SIZE_W-1:0] BOX_SIZE_RST = 8'd32;

	// APB register map
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic        REG_BOX_SIZE = 1'b0;

	// command codes
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// result status codes
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [TEX_W-1:0]   tex;
	} obstacle_t;

endpackage

// ===== sv/bcfhs_if.sv =====
// Valid/ready channel interfaces for command and result beats.
`timescale 1ns / 1ps
interface bcfhs_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [bcfhs_pkg::COORD_W-1:0] pos_x;
	logic signed [bcfhs_pkg::COORD_W-1:0] pos_y;
	logic        [bcfhs_pkg::TEX_W-1:0]   texture_id;

	modport source (output valid, opcode, pos_x, pos_y, texture_id, input ready);
	modport sink   (input valid, opcode, pos_x, pos_y, texture_id, output ready);
endinterface

interface bcfhs_res_if;
	logic                            valid;
	logic                            ready;
	logic                            hit;
	logic [bcfhs_pkg::HIDX_W-1:0]    hit_index;
	logic [bcfhs_pkg::TEX_W-1:0]     hit_texture;
	logic                            status;

	modport source (output valid, hit, hit_index, hit_texture, status, input ready);
	modport sink   (input valid, hit, hit_index, hit_texture, status, output ready);
endinterface

// ===== sv/bcfhs_overlap.sv =====
// Shared inclusive square-overlap compare unit used by the table scan.
`timescale 1ns / 1ps
module bcfhs_overlap (
	input  logic signed [bcfhs_pkg::COORD_W-1:0] qx,
	input  logic signed [bcfhs_pkg::COORD_W-1:0] qy,
	input  bcfhs_pkg::obstacle_t                  obs,
	input  logic        [bcfhs_pkg::SIZE_W-1:0]  size,
	output logic                                  hit
);
	localparam int unsigned EW = bcfhs_pkg::COORD_W + 2;

	logic signed [EW-1:0] qx_e, qy_e, ox_e, oy_e, sz_e;
	logic                 x_ok, y_ok;

	// two guard bits keep the sums exact
	assign qx_e = EW'(qx);
	assign qy_e = EW'(qy);
	assign ox_e = EW'(obs.x);
	assign oy_e = EW'(obs.y);
	assign sz_e = $signed(EW'(size));

	assign x_ok = (qx_e + sz_e >= ox_e) && (qx_e <= ox_e + sz_e);
	assign y_ok = (qy_e + sz_e >= oy_e) && (qy_e <= oy_e + sz_e);
	assign hit  = x_ok && y_ok;
endmodule

// ===== sv/box_collision_first_hit_search.sv =====
// Obstacle box table with first-hit collision search, top level.
//
//  channel  dir  handshake         payload
//  cmd      in   valid/ready       opcode, pos_x, pos_y, texture_id
//  res      out  valid/ready       hit, hit_index, hit_texture, status
//  apb      in   psel/penable      box_size at byte address 0
//
// A query reads the stored slots in order from slot 0 and stops at the first
// hit or after the last stored slot: one table read per cycle through the
// single memory read port into one shared overlap compare.
// cmd.ready is high only while the sequencer is idle; one finished result may
// wait in the output register while the next command is taken.
// arst_n clears the count, the sequencer and box_size (32); the table itself
// is not cleared, no sweep after reset.
`timescale 1ns / 1ps
module box_collision_first_hit_search #(
	parameter int unsigned MAX_OBSTACLES = bcfhs_pkg::MAX_OBSTACLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bcfhs_cmd_if.sink                        cmd,
	bcfhs_res_if.source                      res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bcfhs_pkg::PADDR_W-1:0]    paddr,
	input  logic [bcfhs_pkg::PDATA_W-1:0]    pwdata,
	output logic [bcfhs_pkg::PDATA_W-1:0]    prdata,
	output logic                             pready
);
	localparam int unsigned IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int unsigned CW = $clog2(MAX_OBSTACLES + 1);
	localparam int unsigned HW = bcfhs_pkg::HIDX_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                          state_q;
	logic [CW-1:0]                       count_q;
	logic [CW-1:0]                       scan_q;
	logic [bcfhs_pkg::SIZE_W-1:0]        box_size_q;
	logic signed [bcfhs_pkg::COORD_W-1:0] qx_q, qy_q;

	bcfhs_pkg::obstacle_t                mem_q [MAX_OBSTACLES];
	bcfhs_pkg::obstacle_t                rd_s1;
	logic                                cmp_vld_s1;
	logic [IW-1:0]                       cmp_idx_s1;
	logic                                ovl_hit;

	// pending result, then output register
	logic                                r_hit_q, r_status_q;
	logic [IW-1:0]                       r_idx_q;
	logic [bcfhs_pkg::TEX_W-1:0]         r_tex_q;

	logic                                out_valid_q;
	logic                                o_hit_q, o_status_q;
	logic [IW-1:0]                       o_idx_q;
	logic [bcfhs_pkg::TEX_W-1:0]         o_tex_q;
	logic [IW+HW-1:0]                    idx_ext;

	logic cmd_beat, full, out_free, cfg_wr;

	assign cmd_beat = cmd.valid && cmd.ready;
	assign full     = (count_q >= CW'(MAX_OBSTACLES));
	assign out_free = !out_valid_q || res.ready;
	assign cfg_wr   = psel && penable && pwrite && pready;

	assign cmd.ready = (state_q == S_IDLE);

	// APB
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == bcfhs_pkg::REG_BOX_SIZE) begin
			prdata = bcfhs_pkg::PDATA_W'(box_size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_size_q <= bcfhs_pkg::BOX_SIZE_RST;
		end else if (cfg_wr && paddr[2] == bcfhs_pkg::REG_BOX_SIZE) begin
			box_size_q <= pwdata[bcfhs_pkg::SIZE_W-1:0];
		end
	end

	// obstacle table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd_beat && cmd.opcode == bcfhs_pkg::OP_APPEND && !full) begin
			mem_q[count_q[IW-1:0]] <= '{x: cmd.pos_x, y: cmd.pos_y, tex: cmd.texture_id};
		end
		rd_s1      <= mem_q[scan_q[IW-1:0]];
		cmp_idx_s1 <= scan_q[IW-1:0];
	end

	bcfhs_overlap u_ovl (
		.qx   (qx_q),
		.qy   (qy_q),
		.obs  (rd_s1),
		.size (box_size_q),
		.hit  (ovl_hit)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_beat) begin
						if (cmd.opcode == bcfhs_pkg::OP_APPEND) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_DONE;
						end else begin
							scan_q     <= '0;
							cmp_vld_s1 <= 1'b0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= (scan_q < count_q);
					if (scan_q < count_q) begin
						scan_q <= scan_q + CW'(1);
					end
					if (cmp_vld_s1 && ovl_hit) begin
						state_q <= S_DONE;
					end else if (!cmp_vld_s1 && scan_q >= count_q) begin
						// nothing in flight and nothing left to read
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// query coordinates and pending result
	always_ff @(posedge clk) begin
		if (cmd_beat) begin
			qx_q       <= cmd.pos_x;
			qy_q       <= cmd.pos_y;
			r_hit_q    <= 1'b0;
			r_idx_q    <= '0;
			r_tex_q    <= '0;
			r_status_q <= (cmd.opcode == bcfhs_pkg::OP_APPEND && full) ?
			              bcfhs_pkg::ST_FULL : bcfhs_pkg::ST_DONE;
		end else if (state_q == S_SCAN && cmp_vld_s1 && ovl_hit) begin
			r_hit_q <= 1'b1;
			r_idx_q <= cmp_idx_s1;
			r_tex_q <= rd_s1.tex;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			o_hit_q    <= r_hit_q;
			o_idx_q    <= r_idx_q;
			o_tex_q    <= r_tex_q;
			o_status_q <= r_status_q;
		end
	end

	assign idx_ext = {{HW{1'b0}}, o_idx_q};

	assign res.valid       = out_valid_q;
	assign res.hit         = o_hit_q;
	assign res.hit_index   = idx_ext[HW-1:0];
	assign res.hit_texture = o_tex_q;
	assign res.status      = o_status_q;
endmodule

// ===== sv/bcfhs_checker.sv =====
// Port-level assertions for the box collision search, bound to the top level.
`timescale 1ns / 1ps
`include "box_collision_first_hit_search_macros.svh"
module bcfhs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic                           res_hit,
	input logic [bcfhs_pkg::HIDX_W-1:0]   res_hit_index,
	input logic [bcfhs_pkg::TEX_W-1:0]    res_hit_texture,
	input logic                           res_status
);
	// a result beat stays offered until taken
	`BCFHS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	// one command at a time: ready drops right after a command beat
	`BCFHS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	// a miss reports a clean index and texture
	`BCFHS_ASSERT_NOW(a_miss_clean, clk, arst_n, res_valid && !res_hit,
		res_hit_index == '0 && res_hit_texture == '0)
	// a refused append never reports a hit
	`BCFHS_ASSERT_NOW(a_full_no_hit, clk, arst_n, res_valid && res_status, !res_hit)
endmodule

bind box_collision_first_hit_search bcfhs_checker u_bcfhs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_hit         (res.hit),
	.res_hit_index   (res.hit_index),
	.res_hit_texture (res.hit_texture),
	.res_status      (res.status)
);
